>>> rtl/next_fit_block_assigner_unit_defines.svh
// Assertion macros shared by the next-fit block assigner RTL.
`ifndef NEXT_FIT_BLOCK_ASSIGNER_UNIT_DEFINES_SVH
`define NEXT_FIT_BLOCK_ASSIGNER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define NFBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfba assertion failed");
// Next-cycle implication, checked out of reset.
`define NFBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfba assertion failed");
`else
`define NFBA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NFBA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/nfba_pkg.sv
// Types and constants of the next-fit block assigner.
`default_nettype none

package nfba_pkg;

    localparam int DEFAULT_MAX_BLOCKS = 64;

    localparam int NUM_BLOCKS_W = 7;
    localparam int INDEX_W      = 6;
    localparam int WEIGHT_W     = 40;
    localparam int ITEM_W_W     = 31;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    typedef struct packed {
        logic                operation;
        logic [INDEX_W-1:0]  block_index;
        logic [WEIGHT_W-1:0] block_load;
        logic [WEIGHT_W-1:0] block_limit_value;
        logic [ITEM_W_W-1:0] item_weight;
    } item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] assigned_block;
        logic               overfull;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // write one block, rewind pointer
        logic issue;    // take place item, read block at pointer
        logic advance;  // move to next block, read it
        logic finish;   // commit weight, emit result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic at_last;
        logic over_limit;
    } status_t;

endpackage

`default_nettype wire

>>> rtl/next_fit_block_assigner_unit.sv
// Top level of the next-fit block assigner.
`default_nettype none

// Next-fit block assigner. An item is taken when start is high and busy is
// low. A load item writes one block's weight and limit and rewinds the block
// pointer; busy stays low and no result follows. A place item keeps busy
// high while the blocks from the pointer on are checked, and no new item
// is taken until it is done: each block costs one memory read and one fit
// compare. Its result is marked by result_valid for exactly one cycle, the
// first cycle in which busy is low again; the receiver cannot stall it.
// The block count register is written over cfg_valid/cfg_data, always
// ready; the user must write it only while the unit is idle, which the
// unit itself does not enforce. Blocks must be loaded before a place item
// reads them; there is no clearing pass after reset.
module next_fit_block_assigner_unit #(
    parameter int MAX_BLOCKS = nfba_pkg::DEFAULT_MAX_BLOCKS
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  nfba_pkg::item_t                   item,
    output nfba_pkg::result_t                 result,
    output logic                              result_valid,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [nfba_pkg::NUM_BLOCKS_W-1:0]  cfg_data
);
    import nfba_pkg::*;

    `include "next_fit_block_assigner_unit_defines.svh"

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    nfba_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    nfba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .result       (result),
        .result_valid (result_valid)
    );

    // a load finishes at once and yields nothing
    `NFBA_ASSERT_NXT(a_load_quiet, clk, rst_n, start && !busy && item.operation == OP_LOAD, !busy && !result_valid)
    // a place item keeps the unit busy after it is taken, with no result yet
    `NFBA_ASSERT_NXT(a_place_busy, clk, rst_n, start && !busy && item.operation == OP_PLACE, busy && !result_valid)
    // a result comes only as a busy period ends
    `NFBA_ASSERT_IMP(a_result_after_busy, clk, rst_n, result_valid, !busy && $past(busy))
    // one strobe per place item
    `NFBA_ASSERT_NXT(a_single_strobe, clk, rst_n, result_valid, !result_valid)

endmodule

`default_nettype wire

>>> rtl/nfba_datapath.sv
// Datapath: block weight and limit memories, pointer, fit compare, result register.
`default_nettype none

module nfba_datapath #(
    parameter int MAX_BLOCKS = nfba_pkg::DEFAULT_MAX_BLOCKS
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  nfba_pkg::item_t                   item,
    input  nfba_pkg::cmd_t                    cmd,
    output nfba_pkg::status_t                 status,
    input  wire                               cfg_valid,
    input  wire [nfba_pkg::NUM_BLOCKS_W-1:0]  cfg_data,
    output nfba_pkg::result_t                 result,
    output logic                              result_valid
);
    import nfba_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);

    // block memories, undefined until loaded
    logic [WEIGHT_W-1:0] weight_mem [MAX_BLOCKS];
    logic [WEIGHT_W-1:0] limit_mem  [MAX_BLOCKS];

    logic [NUM_BLOCKS_W-1:0] num_blocks_reg;
    logic [AW-1:0]           ptr_reg, ptr_next;
    logic [AW-1:0]           blk_reg, blk_next;
    logic [ITEM_W_W-1:0]     wgt_reg, wgt_next;
    logic [WEIGHT_W-1:0]     rd_weight_reg;
    logic [WEIGHT_W-1:0]     rd_limit_reg;
    result_t                 result_reg, result_next;
    logic                    result_valid_reg;

    logic [AW-1:0]       last_blk;
    logic [AW-1:0]       ptr_clamped;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                wr_weight_en;
    logic                wr_limit_en;
    logic [WEIGHT_W-1:0] wr_weight;
    logic                load_in_range;
    logic [WEIGHT_W:0]   sum;
    logic [WEIGHT_W-1:0] sum_sat;

    // last block in use: count clamped to 1..MAX_BLOCKS, minus one
    always_comb
    begin
        if (num_blocks_reg == '0)
        begin
            last_blk = '0;
        end
        else if (32'(num_blocks_reg) > MAX_BLOCKS)
        begin
            last_blk = AW'(MAX_BLOCKS - 1);
        end
        else
        begin
            last_blk = AW'(32'(num_blocks_reg) - 32'd1);
        end
    end

    assign ptr_clamped   = (ptr_reg > last_blk) ? last_blk : ptr_reg;
    assign load_in_range = (32'(item.block_index) < MAX_BLOCKS);

    // fit check on the registered read data
    assign sum     = {1'b0, rd_weight_reg} + (WEIGHT_W + 1)'(wgt_reg);
    assign sum_sat = sum[WEIGHT_W] ? {WEIGHT_W{1'b1}} : sum[WEIGHT_W-1:0];

    assign status.at_last    = (blk_reg == last_blk);
    assign status.over_limit = (sum > {1'b0, rd_limit_reg});

    // memory port steering
    always_comb
    begin
        rd_addr      = cmd.advance ? (blk_reg + AW'(1)) : ptr_clamped;
        wr_addr      = cmd.load ? AW'(item.block_index) : blk_reg;
        wr_weight    = cmd.load ? item.block_load : sum_sat;
        wr_weight_en = (cmd.load && load_in_range) || cmd.finish;
        wr_limit_en  = cmd.load && load_in_range;
    end

    always_ff @(posedge clk)
    begin
        if (wr_weight_en)
        begin
            weight_mem[wr_addr] <= wr_weight;
        end
        if (wr_limit_en)
        begin
            limit_mem[wr_addr] <= item.block_limit_value;
        end
        rd_weight_reg <= weight_mem[rd_addr];
        rd_limit_reg  <= limit_mem[rd_addr];
    end

    // pointer, current block and item weight
    always_comb
    begin
        ptr_next = ptr_reg;
        blk_next = blk_reg;
        wgt_next = wgt_reg;
        if (cmd.load)
        begin
            ptr_next = '0;
        end
        if (cmd.issue)
        begin
            blk_next = ptr_clamped;
            wgt_next = item.item_weight;
        end
        if (cmd.advance)
        begin
            blk_next = blk_reg + AW'(1);
        end
        if (cmd.finish)
        begin
            ptr_next = blk_reg;
        end
    end

    // result of a finished place item
    always_comb
    begin
        result_next.assigned_block = INDEX_W'(blk_reg);
        result_next.overfull       = status.at_last && (sum_sat > rd_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg   <= NUM_BLOCKS_W'(1);
            ptr_reg          <= '0;
            blk_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                num_blocks_reg <= cfg_data;
            end
            ptr_reg          <= ptr_next;
            blk_reg          <= blk_next;
            result_valid_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        wgt_reg <= wgt_next;
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

>>> rtl/nfba_controller.sv
// Controller: sequences load and place items over the datapath.
`default_nettype none

module nfba_controller (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    input  wire                operation,
    input  nfba_pkg::status_t  status,
    output nfba_pkg::cmd_t     cmd,
    output logic               busy
);
    import nfba_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_PLACE)
                    begin
                        cmd.issue  = 1'b1;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                if (!status.at_last && status.over_limit)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        busy_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

>>> test/next_fit_block_assigner_unit_test.sv
// Self-checking testbench for the next-fit block assigner unit.
`timescale 1ns / 1ps

module next_fit_block_assigner_unit_test;
    import nfba_pkg::*;

    localparam int BLOCK_SLOTS = DEFAULT_MAX_BLOCKS;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT = 500000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    item_t item = '0;
    result_t result;
    logic result_valid;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [NUM_BLOCKS_W-1:0] cfg_data = '0;

    // items waiting for the driver, placements waiting for the result port
    item_t pending_items[$];
    result_t placements_due[$];

    // predicted block state
    logic [WEIGHT_W-1:0] blk_weight[BLOCK_SLOTS];
    logic [WEIGHT_W-1:0] blk_limit[BLOCK_SLOTS];
    int fit_ptr = 0;
    logic [NUM_BLOCKS_W-1:0] blocks_reg = 7'd1;

    // stimulus bookkeeping
    bit [BLOCK_SLOTS-1:0] block_ready = '0;
    int items_queued = 0;
    int items_accepted = 0;
    bit took_item = 1'b0;
    bit cfg_written = 1'b0;
    bit no_gaps = 1'b0;
    int gap_left = 0;
    int fail_count = 0;
    int cycle_count = 0;

    next_fit_block_assigner_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result      (result),
        .result_valid(result_valid),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("next_fit_block_assigner_unit_test NOT OK");
            $finish;
        end
    end

    // Count 0 acts as 1, anything above the slot count as the slot count
    function automatic int active_blocks(logic [NUM_BLOCKS_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > BLOCK_SLOTS)
            return BLOCK_SLOTS;
        return int'(v);
    endfunction

    // Next-fit step on the predicted state; queues the placement of a place item
    task automatic apply_item(input item_t it);
        int k;
        int b;
        logic [WEIGHT_W:0] total;
        result_t r;
        if (it.operation == OP_LOAD)
        begin
            blk_weight[it.block_index] = it.block_load;
            blk_limit[it.block_index] = it.block_limit_value;
            fit_ptr = 0;
        end
        else
        begin
            k = active_blocks(blocks_reg);
            b = fit_ptr;
            if (b >= k)
                b = k - 1;
            while (b + 1 < k &&
                   ({1'b0, blk_weight[b]} + it.item_weight > {1'b0, blk_limit[b]}))
                b++;
            total = {1'b0, blk_weight[b]} + it.item_weight;
            blk_weight[b] = total[WEIGHT_W] ? '1 : total[WEIGHT_W-1:0];
            fit_ptr = b;
            r.assigned_block = b[INDEX_W-1:0];
            r.overfull = (b + 1 == k) && (blk_weight[b] > blk_limit[b]);
            placements_due.push_back(r);
        end
    endtask

    // Monitor: check results, then predict the item taken at this edge
    always @(posedge clk)
    begin : watch
        result_t due;
        took_item = 1'b0;
        cfg_written = 1'b0;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (placements_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, got block %0d overfull %0b",
                             $time, result.assigned_block, result.overfull);
                end
                else
                begin
                    due = placements_due.pop_front();
                    if (result.assigned_block !== due.assigned_block)
                    begin
                        fail_count++;
                        $display("%0t: assigned_block mismatch, expected %0d, got %0d",
                                 $time, due.assigned_block, result.assigned_block);
                    end
                    if (result.overfull !== due.overfull)
                    begin
                        fail_count++;
                        $display("%0t: overfull mismatch, expected %0b, got %0b",
                                 $time, due.overfull, result.overfull);
                    end
                end
            end
            if (start && !busy)
            begin
                took_item = 1'b1;
                items_accepted++;
                apply_item(item);
            end
            if (cfg_valid && cfg_ready)
            begin
                cfg_written = 1'b1;
                blocks_reg = cfg_data;
            end
        end
    end

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: hold start until the item is taken, then idle or send the next one
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !took_item)
            start <= 1'b1;
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left--;
        end
        else if (pending_items.size() > 0)
        begin
            item <= pending_items.pop_front();
            start <= 1'b1;
            gap_left = pick_gap();
        end
        else
            start <= 1'b0;
    end

    function automatic logic [WEIGHT_W-1:0] rand40();
        logic [7:0] hi;
        hi = 8'($urandom());
        return {hi, $urandom()};
    endfunction

    function automatic logic [ITEM_W_W-1:0] weight_mask(int s);
        return ITEM_W_W'((64'd1 << s) - 1);
    endfunction

    task automatic queue_load(input int idx, input logic [WEIGHT_W-1:0] ld,
                              input logic [WEIGHT_W-1:0] lim);
        item_t it;
        it.operation = OP_LOAD;
        it.block_index = INDEX_W'(idx);
        it.block_load = ld;
        it.block_limit_value = lim;
        it.item_weight = ITEM_W_W'($urandom());
        pending_items.push_back(it);
        items_queued++;
        block_ready[idx] = 1'b1;
    endtask

    task automatic queue_place(input logic [ITEM_W_W-1:0] w);
        item_t it;
        it.operation = OP_PLACE;
        it.block_index = INDEX_W'($urandom());
        it.block_load = rand40();
        it.block_limit_value = rand40();
        it.item_weight = w;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Block contents scaled to the phase's item weights, with saturation and
    // already-full blocks mixed in
    task automatic queue_block(input int idx, input logic [ITEM_W_W-1:0] m);
        int r;
        logic [WEIGHT_W-1:0] lim;
        logic [WEIGHT_W-1:0] ld;
        r = $urandom_range(0, 11);
        if (r == 0)
        begin
            lim = '1;
            ld = '1 - WEIGHT_W'($urandom_range(0, 1000));
        end
        else if (r == 1)
        begin
            lim = rand40();
            ld = rand40();
        end
        else
        begin
            lim = WEIGHT_W'(m & ITEM_W_W'($urandom())) * WEIGHT_W'($urandom_range(1, 6));
            if (r < 4)
                ld = lim + WEIGHT_W'($urandom_range(1, 50));
            else
                ld = lim >> $urandom_range(0, 10);
        end
        queue_load(idx, ld, lim);
    endtask

    function automatic logic [ITEM_W_W-1:0] next_weight(logic [ITEM_W_W-1:0] m);
        int r;
        r = $urandom_range(0, 29);
        if (r == 0)
            return '1;
        if (r < 4)
            return ITEM_W_W'($urandom());
        return m & ITEM_W_W'($urandom());
    endfunction

    task automatic write_block_count(input logic [NUM_BLOCKS_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(negedge clk);
        while (!cfg_written);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued item is taken and every placement has come back
    task automatic wait_idle();
        while (items_accepted != items_queued || placements_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One phase: set the count, load every block in use that needs it, then
    // place items with the odd stray load mixed in
    task automatic run_phase(input logic [NUM_BLOCKS_W-1:0] nb);
        int k;
        int n;
        int i;
        int idx;
        bit reload;
        bit down;
        logic [ITEM_W_W-1:0] m;
        write_block_count(nb);
        no_gaps = ($urandom_range(0, 3) == 0);
        k = active_blocks(nb);
        m = weight_mask($urandom_range(1, ITEM_W_W));
        reload = ($urandom_range(0, 2) == 0);
        down = 1'($urandom_range(0, 1));
        for (i = 0; i < k; i++)
        begin
            idx = down ? k - 1 - i : i;
            if (reload || !block_ready[idx])
                queue_block(idx, m);
        end
        n = $urandom_range(15, 45);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                queue_block($urandom_range(0, BLOCK_SLOTS - 1), m);
            else
                queue_place(next_weight(m));
        end
        wait_idle();
    endtask

    initial
    begin : stimulus
        int phase_no;
        int r;
        logic [NUM_BLOCKS_W-1:0] nb;
        for (int i = 0; i < BLOCK_SLOTS; i++)
        begin
            blk_weight[i] = '0;
            blk_limit[i] = '0;
        end
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // one block at the reset count: exact fit, then overfull on the last block
        queue_load(0, 40'd0, 40'd100);
        queue_place(31'd0);
        queue_place(31'd100);
        queue_place(31'd1);
        wait_idle();

        // count zero acts as one; weight saturation; zero limit
        write_block_count(7'd0);
        queue_load(0, 40'hFF_FFFF_FFFE, '1);
        queue_place('1);
        queue_place(31'd5);
        queue_load(0, '1, 40'd0);
        queue_place(31'd0);
        wait_idle();

        // skip a full block, then overfill the last one
        write_block_count(7'd3);
        queue_load(0, 40'd10, 40'd10);
        queue_load(1, 40'd0, 40'd10);
        queue_load(2, 40'd0, 40'd5);
        queue_place(31'd5);
        queue_place(31'd6);
        wait_idle();

        // shrink the count below the pointer
        write_block_count(7'd2);
        queue_place(31'd0);
        wait_idle();

        // growing the count again leaves the pointer where it was
        write_block_count(7'd3);
        queue_place(31'd0);
        wait_idle();

        // random phases, starting at the largest counts
        phase_no = 0;
        r = items_queued + RANDOM_ITEMS;
        while (items_queued < r)
        begin
            case ($urandom_range(0, 15))
                0: nb = 7'd0;
                1: nb = 7'd1;
                2: nb = NUM_BLOCKS_W'($urandom_range(BLOCK_SLOTS + 1, 127));
                3: nb = NUM_BLOCKS_W'(BLOCK_SLOTS);
                4, 5: nb = NUM_BLOCKS_W'($urandom_range(9, BLOCK_SLOTS - 1));
                default: nb = NUM_BLOCKS_W'($urandom_range(2, 8));
            endcase
            if (phase_no == 0)
                nb = 7'd127;
            else if (phase_no == 1)
                nb = NUM_BLOCKS_W'(BLOCK_SLOTS);
            run_phase(nb);
            phase_no++;
        end

        wait_idle();
        repeat (16) @(negedge clk);
        if (placements_due.size() != 0)
        begin
            fail_count++;
            $display("%0t: placements missing, expected %0d more, got none",
                     $time, placements_due.size());
        end
        if (fail_count == 0)
            $display("next_fit_block_assigner_unit_test OK");
        else
            $display("next_fit_block_assigner_unit_test NOT OK");
        $finish;
    end

endmodule
